// ===== src/imu_acc_pkg.sv =====
// Package for the IMU sample accumulator: stream payload layouts, register indexes,
// bus outcome codes, state encoding and the axis orientation table.
// No dependencies; used by imu_sample_accumulate_average_top.
package imu_acc_pkg;

   localparam int FRAC_BITS_DEFAULT = 8;
   localparam int SUM_W = 32;
   localparam int RAW_W = 16;
   localparam int CNT_W = 16;
   localparam int AVG_W = 24;
   localparam int TIME_W = 32;
   localparam int NUM_CH = 6;
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 200;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_INTERVAL = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLE_PERIOD = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORIENTATION = 2'd2;

   localparam logic [15:0] MIN_INTERVAL_RESET = 16'd20000;
   localparam logic [15:0] SAMPLE_PERIOD_RESET = 16'd20000;

   localparam logic [1:0] BUS_OK = 2'd0;
   localparam logic [1:0] BUS_DATA_FAIL = 2'd2;
   localparam int STATUS_READY_BIT = 0;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   // Channel indexes of the stored sums.
   localparam logic [2:0] CH_AX = 3'd0;
   localparam logic [2:0] CH_AY = 3'd1;
   localparam logic [2:0] CH_AZ = 3'd2;
   localparam logic [2:0] CH_GX = 3'd3;
   localparam logic [2:0] CH_GY = 3'd4;
   localparam logic [2:0] CH_GZ = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_GATE = 5'b00010,
      ST_ADD  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   typedef struct packed {
      logic [5:0]              pad;
      logic signed [RAW_W-1:0] gyro_z_raw;
      logic signed [RAW_W-1:0] gyro_y_raw;
      logic signed [RAW_W-1:0] gyro_x_raw;
      logic signed [RAW_W-1:0] accel_z_raw;
      logic signed [RAW_W-1:0] accel_y_raw;
      logic signed [RAW_W-1:0] accel_x_raw;
      logic [7:0]              status_byte;
      logic [1:0]              bus_outcome;
      logic [TIME_W-1:0]       now_us;
   } req_data_type;

   typedef struct packed {
      logic [6:0]              pad;
      logic [CNT_W-1:0]        samples_used;
      logic [TIME_W-1:0]       elapsed_us;
      logic signed [AVG_W-1:0] accel_z_avg;
      logic signed [AVG_W-1:0] accel_y_avg;
      logic signed [AVG_W-1:0] accel_x_avg;
      logic signed [AVG_W-1:0] gyro_z_avg;
      logic signed [AVG_W-1:0] gyro_y_avg;
      logic signed [AVG_W-1:0] gyro_x_avg;
      logic                    accepted;
   } rsp_data_type;

   // Result slots are gyro X, Y, Z, then accel X, Y, Z.
   function automatic logic [2:0] map_src(input logic [2:0] slot, input logic orient);
      logic [2:0] src;
      src = CH_GX;
      unique case (slot)
         3'd0: src = orient ? CH_GY : CH_GX;
         3'd1: src = orient ? CH_GX : CH_GY;
         3'd2: src = CH_GZ;
         3'd3: src = orient ? CH_AY : CH_AX;
         3'd4: src = orient ? CH_AX : CH_AY;
         3'd5: src = CH_AZ;
         default: src = CH_GX;
      endcase
      return src;
   endfunction

   function automatic logic map_neg(input logic [2:0] slot, input logic orient);
      logic ng;
      ng = 1'b0;
      unique case (slot)
         3'd0, 3'd3: ng = !orient;
         3'd2, 3'd5: ng = 1'b1;
         default: ng = 1'b0;
      endcase
      return ng;
   endfunction

endpackage

// ===== src/imu_sample_accumulate_average_top.sv =====
// Six-axis IMU sample accumulator with averaging read-out, bit-serial datapath.
// Depends on imu_acc_pkg for payload layouts, codes and the orientation table.
//
// Usage: items enter on the req_ stream. req_tuser selects a sample attempt (0)
// or a fetch of the averages (1). Every item produces exactly one item on the
// rsp_ stream. A sample attempt is rate-gated against the time of the last
// accepted read and, if it passes with a good bus and data-ready status, its six
// readings are added into six 32-bit running sums. A fetch returns the six
// averages in signed fixed point with FRAC_BITS fraction bits plus the elapsed
// time, then clears the sums and the count.
// Flow: a refused or data-less sample goes from accept through the gate state to
// the result register, an accumulated sample also through the add state (the
// sums are added one bit per cycle), a fetch with samples through the divide
// state (six restoring dividers, one quotient bit per cycle each). The block
// works on one item at a time and takes the next once the result is registered.
// The output register frees the block: the next item is accepted while a result
// still waits on rsp_tready; a further result is held back until it is taken.
// Reset is synchronous and active high; it clears the sums and the count, sets
// the registers to their defaults and drops rsp_tvalid. Registers must be written
// through csr_ by the user while no item is in flight; the block does not enforce it.
module imu_sample_accumulate_average_top
   import imu_acc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // now_us, bus_outcome, status_byte, accel_x/y/z_raw, gyro_x/y/z_raw, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // accepted, gyro_x/y/z_avg, accel_x/y/z_avg, elapsed_us, samples_used, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DVD_W = SUM_W + FRAC_BITS;
   localparam int DCNT_W = $clog2(DVD_W);
   localparam int BCNT_W = $clog2(SUM_W);
   localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DVD_W - 1);
   localparam logic [BCNT_W-1:0] BCNT_LAST = BCNT_W'(SUM_W - 1);

   state_type state_ff, state_in;

   logic [15:0] min_interval_ff;
   logic [15:0] sample_period_ff;
   logic        orient_ff;

   logic [SUM_W-1:0]  sums_ff [NUM_CH];
   logic [CNT_W-1:0]  count_ff;
   logic [TIME_W-1:0] last_time_ff;
   logic [TIME_W-1:0] elapsed_ff;

   logic              type_ff;
   logic [TIME_W-1:0] now_ff;
   logic [1:0]        bus_ff;
   logic [7:0]        status_ff;
   logic [RAW_W-1:0]  raw_ff [NUM_CH];
   logic              carry_ff [NUM_CH];
   logic [BCNT_W-1:0] bit_cnt_ff;

   logic [DVD_W-1:0]  dvd_ff [NUM_CH];
   logic [DVD_W-1:0]  quo_ff [NUM_CH];
   logic [CNT_W-1:0]  rem_ff [NUM_CH];
   logic              neg_ff [NUM_CH];
   logic [CNT_W-1:0]  div_n_ff;
   logic [DCNT_W-1:0] div_cnt_ff;

   logic acc_ok_ff;
   logic avg_valid_ff;

   logic         rsp_valid_ff;
   rsp_data_type rsp_data_ff, rsp_data_in;

   req_data_type      req_data;
   logic [TIME_W-1:0] gap;
   logic              gate_ok;
   logic              out_free;
   logic [AVG_W-1:0]  avg [NUM_CH];

   assign req_data = req_data_type'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = RSP_DATA_W'(rsp_data_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign gap = now_ff - last_time_ff;
   assign gate_ok = (gap >= {16'd0, min_interval_ff})
                 && (bus_ff == BUS_OK || bus_ff == BUS_DATA_FAIL)
                 && status_ff[STATUS_READY_BIT];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_GATE;
            end
         end
         ST_GATE: begin
            if (type_ff == REQ_FETCH) begin
               state_in = (count_ff == '0) ? ST_DONE : ST_DIV;
            end else begin
               state_in = (gate_ok && bus_ff == BUS_OK) ? ST_ADD : ST_DONE;
            end
         end
         ST_ADD: begin
            if (bit_cnt_ff == BCNT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_cnt_ff == DCNT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Saturate each quotient to the 24-bit signed range and apply its sign.
   always_comb begin
      for (int l = 0; l < NUM_CH; l++) begin
         if (!avg_valid_ff) begin
            avg[l] = '0;
         end else if (neg_ff[l]) begin
            if ((|quo_ff[l][DVD_W-1:AVG_W]) || (quo_ff[l][AVG_W-1] && (|quo_ff[l][AVG_W-2:0])))
            begin
               avg[l] = {1'b1, {(AVG_W-1){1'b0}}};
            end else begin
               avg[l] = -quo_ff[l][AVG_W-1:0];
            end
         end else begin
            if (|quo_ff[l][DVD_W-1:AVG_W-1]) begin
               avg[l] = {1'b0, {(AVG_W-1){1'b1}}};
            end else begin
               avg[l] = quo_ff[l][AVG_W-1:0];
            end
         end
      end
   end

   always_comb begin
      rsp_data_in              = '0;
      rsp_data_in.accepted     = acc_ok_ff;
      rsp_data_in.gyro_x_avg   = avg[0];
      rsp_data_in.gyro_y_avg   = avg[1];
      rsp_data_in.gyro_z_avg   = avg[2];
      rsp_data_in.accel_x_avg  = avg[3];
      rsp_data_in.accel_y_avg  = avg[4];
      rsp_data_in.accel_z_avg  = avg[5];
      rsp_data_in.elapsed_us   = elapsed_ff;
      rsp_data_in.samples_used = avg_valid_ff ? div_n_ff : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         min_interval_ff  <= MIN_INTERVAL_RESET;
         sample_period_ff <= SAMPLE_PERIOD_RESET;
         orient_ff        <= 1'b0;
         count_ff         <= '0;
         last_time_ff     <= '0;
         elapsed_ff       <= TIME_W'(1);
         rsp_valid_ff     <= 1'b0;
         acc_ok_ff        <= 1'b0;
         avg_valid_ff     <= 1'b0;
         for (int l = 0; l < NUM_CH; l++) begin
            sums_ff[l] <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (csr_addr)
               CSR_MIN_INTERVAL:  min_interval_ff <= csr_wdata;
               CSR_SAMPLE_PERIOD: sample_period_ff <= csr_wdata;
               CSR_ORIENTATION:   orient_ff <= csr_wdata[0];
               default: ;
            endcase
         end

         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               avg_valid_ff <= 1'b0;
               acc_ok_ff    <= 1'b0;
            end
            ST_GATE: begin
               if (type_ff == REQ_FETCH) begin
                  if (count_ff != '0) begin
                     acc_ok_ff    <= 1'b1;
                     avg_valid_ff <= 1'b1;
                     elapsed_ff   <= TIME_W'(count_ff) * TIME_W'(sample_period_ff);
                     count_ff     <= '0;
                     for (int l = 0; l < NUM_CH; l++) begin
                        sums_ff[l] <= '0;
                     end
                  end
               end else begin
                  acc_ok_ff <= gate_ok;
                  if (gate_ok) begin
                     last_time_ff <= now_ff;
                  end
               end
            end
            ST_ADD: begin
               for (int l = 0; l < NUM_CH; l++) begin
                  sums_ff[l] <= {sums_ff[l][0] ^ raw_ff[l][0] ^ carry_ff[l],
                                 sums_ff[l][SUM_W-1:1]};
               end
               if (bit_cnt_ff == BCNT_LAST) begin
                  count_ff <= count_ff + CNT_W'(1);
                  if (count_ff == '1) begin
                     for (int l = 0; l < NUM_CH; l++) begin
                        sums_ff[l] <= '0;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Payload and datapath registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               type_ff   <= req_tuser;
               now_ff    <= req_data.now_us;
               bus_ff    <= req_data.bus_outcome;
               status_ff <= req_data.status_byte;
               raw_ff[CH_AX] <= req_data.accel_x_raw;
               raw_ff[CH_AY] <= req_data.accel_y_raw;
               raw_ff[CH_AZ] <= req_data.accel_z_raw;
               raw_ff[CH_GX] <= req_data.gyro_x_raw;
               raw_ff[CH_GY] <= req_data.gyro_y_raw;
               raw_ff[CH_GZ] <= req_data.gyro_z_raw;
            end
         end
         ST_GATE: begin
            bit_cnt_ff <= '0;
            div_cnt_ff <= '0;
            div_n_ff   <= count_ff;
            for (int l = 0; l < NUM_CH; l++) begin
               logic [SUM_W-1:0] src;
               logic             ng;
               src = sums_ff[map_src(3'(l), orient_ff)];
               ng  = map_neg(3'(l), orient_ff);
               carry_ff[l] <= 1'b0;
               neg_ff[l]   <= ng ? (!src[SUM_W-1] && (src != '0)) : src[SUM_W-1];
               dvd_ff[l]   <= DVD_W'(src[SUM_W-1] ? -src : src) << FRAC_BITS;
               rem_ff[l]   <= '0;
               quo_ff[l]   <= '0;
            end
         end
         ST_ADD: begin
            bit_cnt_ff <= bit_cnt_ff + BCNT_W'(1);
            for (int l = 0; l < NUM_CH; l++) begin
               raw_ff[l]   <= {raw_ff[l][RAW_W-1], raw_ff[l][RAW_W-1:1]};
               carry_ff[l] <= (sums_ff[l][0] & raw_ff[l][0])
                            | (sums_ff[l][0] & carry_ff[l])
                            | (raw_ff[l][0] & carry_ff[l]);
            end
         end
         ST_DIV: begin
            div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
            for (int l = 0; l < NUM_CH; l++) begin
               logic [CNT_W:0] trial;
               logic           ge;
               trial = {rem_ff[l], dvd_ff[l][DVD_W-1]};
               ge    = trial >= {1'b0, div_n_ff};
               rem_ff[l] <= ge ? CNT_W'(trial - {1'b0, div_n_ff}) : trial[CNT_W-1:0];
               quo_ff[l] <= {quo_ff[l][DVD_W-2:0], ge};
               dvd_ff[l] <= dvd_ff[l] << 1;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== verif/imu_acc_checker.sv =====
// Result checker for the IMU sample accumulator: watches the req_, rsp_ and csr_ ports,
// predicts the result of every accepted item and compares it field by field.
// Depends on imu_acc_pkg for the payload layouts, register indexes and codes.
module imu_acc_checker
   import imu_acc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    outstanding,
   output int                    results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint AVG_TOP = (longint'(1) << (AVG_W - 1)) - 1;

   logic [15:0]       min_interval;
   logic [15:0]       sample_period;
   logic              orient;
   logic [SUM_W-1:0]  channel_total [NUM_CH];
   logic [CNT_W-1:0]  sample_count;
   logic [TIME_W-1:0] last_read_time;
   logic [TIME_W-1:0] elapsed_time;
   rsp_data_type      pending_replies[$];

   // Signed sum times 2^FRAC_BITS over the count, truncated toward zero and saturated.
   function automatic logic [AVG_W-1:0] scaled_average(input logic [SUM_W-1:0] total,
                                                       input logic negate,
                                                       input logic [CNT_W-1:0] count);
      longint value;
      longint quotient;
      value = longint'(signed'(total));
      if (negate) begin
         value = -value;
      end
      quotient = (value < 0) ? -value : value;
      quotient = (quotient << FRAC_BITS) / longint'(count);
      if (value < 0) begin
         quotient = (quotient > AVG_TOP + 1) ? -(AVG_TOP + 1) : -quotient;
      end else if (quotient > AVG_TOP) begin
         quotient = AVG_TOP;
      end
      return quotient[AVG_W-1:0];
   endfunction

   task automatic predict_reply(input logic kind, input req_data_type item);
      rsp_data_type      reply;
      logic [RAW_W-1:0]  raw [NUM_CH];
      logic [TIME_W-1:0] since_last;
      reply = '0;
      if (kind == REQ_SAMPLE) begin
         raw[CH_AX] = item.accel_x_raw;
         raw[CH_AY] = item.accel_y_raw;
         raw[CH_AZ] = item.accel_z_raw;
         raw[CH_GX] = item.gyro_x_raw;
         raw[CH_GY] = item.gyro_y_raw;
         raw[CH_GZ] = item.gyro_z_raw;
         since_last = item.now_us - last_read_time;
         if (since_last >= TIME_W'(min_interval) &&
             (item.bus_outcome == BUS_OK || item.bus_outcome == BUS_DATA_FAIL) &&
             item.status_byte[STATUS_READY_BIT]) begin
            reply.accepted = 1'b1;
            last_read_time = item.now_us;
            if (item.bus_outcome == BUS_OK) begin
               for (int ch = 0; ch < NUM_CH; ch++) begin
                  channel_total[ch] += {{(SUM_W-RAW_W){raw[ch][RAW_W-1]}}, raw[ch]};
               end
               sample_count++;
               if (sample_count == '0) begin
                  for (int ch = 0; ch < NUM_CH; ch++) begin
                     channel_total[ch] = '0;
                  end
               end
            end
         end
         reply.elapsed_us = elapsed_time;
         reply.samples_used = sample_count;
      end else if (sample_count == '0) begin
         reply.elapsed_us = elapsed_time;
      end else begin
         elapsed_time = TIME_W'(sample_count) * TIME_W'(sample_period);
         if (!orient) begin
            reply.gyro_x_avg  = scaled_average(channel_total[CH_GX], 1'b1, sample_count);
            reply.gyro_y_avg  = scaled_average(channel_total[CH_GY], 1'b0, sample_count);
            reply.accel_x_avg = scaled_average(channel_total[CH_AX], 1'b1, sample_count);
            reply.accel_y_avg = scaled_average(channel_total[CH_AY], 1'b0, sample_count);
         end else begin
            reply.gyro_x_avg  = scaled_average(channel_total[CH_GY], 1'b0, sample_count);
            reply.gyro_y_avg  = scaled_average(channel_total[CH_GX], 1'b0, sample_count);
            reply.accel_x_avg = scaled_average(channel_total[CH_AY], 1'b0, sample_count);
            reply.accel_y_avg = scaled_average(channel_total[CH_AX], 1'b0, sample_count);
         end
         reply.gyro_z_avg  = scaled_average(channel_total[CH_GZ], 1'b1, sample_count);
         reply.accel_z_avg = scaled_average(channel_total[CH_AZ], 1'b1, sample_count);
         reply.accepted = 1'b1;
         reply.elapsed_us = elapsed_time;
         reply.samples_used = sample_count;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            channel_total[ch] = '0;
         end
         sample_count = '0;
      end
      pending_replies.push_back(reply);
   endtask

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                  $time, field, want, got);
      end
   endfunction

   task automatic check_reply(input rsp_data_type got);
      rsp_data_type want;
      if (pending_replies.size() == 0) begin
         fail_count++;
         $display("%0t ns: unexpected result, expected none, actual %0h", $time, got);
      end else begin
         want = pending_replies.pop_front();
         results_checked++;
         check_field("accepted", want.accepted, got.accepted);
         check_field("gyro_x_avg", want.gyro_x_avg, got.gyro_x_avg);
         check_field("gyro_y_avg", want.gyro_y_avg, got.gyro_y_avg);
         check_field("gyro_z_avg", want.gyro_z_avg, got.gyro_z_avg);
         check_field("accel_x_avg", want.accel_x_avg, got.accel_x_avg);
         check_field("accel_y_avg", want.accel_y_avg, got.accel_y_avg);
         check_field("accel_z_avg", want.accel_z_avg, got.accel_z_avg);
         check_field("elapsed_us", want.elapsed_us, got.elapsed_us);
         check_field("samples_used", want.samples_used, got.samples_used);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         min_interval = MIN_INTERVAL_RESET;
         sample_period = SAMPLE_PERIOD_RESET;
         orient = 1'b0;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            channel_total[ch] = '0;
         end
         sample_count = '0;
         last_read_time = '0;
         elapsed_time = TIME_W'(1);
         pending_replies.delete();
         outstanding = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_MIN_INTERVAL: min_interval = csr_wdata;
               CSR_SAMPLE_PERIOD: sample_period = csr_wdata;
               CSR_ORIENTATION: orient = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            check_reply(rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            predict_reply(req_tuser, req_tdata);
         end
         outstanding = pending_replies.size();
      end
   end

endmodule

// ===== verif/tb_top.sv =====
// Top of the IMU sample accumulator testbench: clock, reset, directed and random
// stimulus under several idling patterns, and the verdict.
// Depends on imu_acc_pkg, imu_sample_accumulate_average_top and imu_acc_checker.
module tb_top;
   import imu_acc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CYCLE_LIMIT = 64'd1_000_000;
   localparam int PHASE_ITEMS = 312;
   localparam logic [1:0] BUS_STATUS_FAIL = 2'd1;
   localparam logic [1:0] BUS_RESERVED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int          fail_count;
   int          outstanding;
   int          results_checked;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          hold_cycles = 0;
   int          items_sent = 0;
   int          fetches_sent = 0;
   int          settings_used = 1;
   int          min_gap = MIN_INTERVAL_RESET;
   logic [31:0] tb_now = '0;
   longint      cycle_count = 0;

   imu_sample_accumulate_average_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   imu_acc_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, outstanding);
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [15:0] random_raw();
      case ($urandom_range(19))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_data_type random_noise();
      req_data_type item;
      item = '0;
      item.now_us = $urandom;
      item.bus_outcome = 2'($urandom);
      item.status_byte = 8'($urandom);
      item.accel_x_raw = random_raw();
      item.accel_y_raw = random_raw();
      item.accel_z_raw = random_raw();
      item.gyro_x_raw = random_raw();
      item.gyro_y_raw = random_raw();
      item.gyro_z_raw = random_raw();
      return item;
   endfunction

   function automatic req_data_type sample_fields(input logic [31:0] now,
                                                  input logic [1:0] bus,
                                                  input logic [7:0] status,
                                                  input int ax, input int ay, input int az,
                                                  input int gx, input int gy, input int gz);
      req_data_type item;
      item = '0;
      item.now_us = now;
      item.bus_outcome = bus;
      item.status_byte = status;
      item.accel_x_raw = 16'(ax);
      item.accel_y_raw = 16'(ay);
      item.accel_z_raw = 16'(az);
      item.gyro_x_raw = 16'(gx);
      item.gyro_y_raw = 16'(gy);
      item.gyro_z_raw = 16'(gz);
      return item;
   endfunction

   task automatic send_item(input logic kind, input req_data_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= item;
      items_sent++;
      if (kind == REQ_FETCH) begin
         fetches_sent++;
      end
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic write_settings(input logic [15:0] interval, input logic [15:0] period,
                                 input logic orient);
      csr_we <= 1'b1;
      csr_addr <= CSR_MIN_INTERVAL;
      csr_wdata <= interval;
      @(posedge clock);
      csr_addr <= CSR_SAMPLE_PERIOD;
      csr_wdata <= period;
      @(posedge clock);
      csr_addr <= CSR_ORIENTATION;
      csr_wdata <= {15'd0, orient};
      @(posedge clock);
      csr_we <= 1'b0;
      min_gap = interval;
      settings_used++;
   endtask

   // Mostly well-paced good samples with random readings, some fetches, and a
   // share of early, failed, not-ready and arbitrary items.
   task automatic random_item();
      req_data_type item;
      int           pick;
      item = random_noise();
      if ($urandom_range(99) < 12) begin
         send_item(REQ_FETCH, item);
      end else begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            tb_now = tb_now + min_gap + $urandom_range(2000);
         end else if (pick < 90) begin
            tb_now = tb_now + $urandom_range(min_gap);
         end else begin
            tb_now = $urandom;
         end
         item.now_us = tb_now;
         pick = $urandom_range(99);
         if (pick < 85) begin
            item.bus_outcome = BUS_OK;
         end else if (pick < 92) begin
            item.bus_outcome = BUS_DATA_FAIL;
         end else if (pick < 97) begin
            item.bus_outcome = BUS_STATUS_FAIL;
         end else begin
            item.bus_outcome = BUS_RESERVED;
         end
         item.status_byte[STATUS_READY_BIT] = ($urandom_range(99) < 88);
         send_item(REQ_SAMPLE, item);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = REQ_SAMPLE;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = CSR_MIN_INTERVAL;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_item(REQ_FETCH, random_noise());
      send_item(REQ_SAMPLE, sample_fields(0, BUS_OK, 8'h01, 1, 1, 1, 1, 1, 1));
      send_item(REQ_SAMPLE, sample_fields(20000, BUS_OK, 8'h01,
                                          -32768, -32768, -32768, -32768, -32768, -32768));
      send_item(REQ_SAMPLE, sample_fields(40000, BUS_OK, 8'hfe, 5, 5, 5, 5, 5, 5));
      send_item(REQ_SAMPLE, sample_fields(40000, BUS_STATUS_FAIL, 8'hff, 5, 5, 5, 5, 5, 5));
      send_item(REQ_SAMPLE, sample_fields(40000, BUS_RESERVED, 8'hff, 5, 5, 5, 5, 5, 5));
      send_item(REQ_SAMPLE, sample_fields(40000, BUS_DATA_FAIL, 8'h01, 9, 9, 9, 9, 9, 9));
      send_item(REQ_SAMPLE, sample_fields(59999, BUS_OK, 8'h01, 7, 7, 7, 7, 7, 7));
      send_item(REQ_FETCH, random_noise());
      send_item(REQ_SAMPLE, sample_fields(60000, BUS_OK, 8'hff,
                                          32767, 32767, 32767, 32767, 32767, 32767));
      send_item(REQ_SAMPLE, sample_fields(80000, BUS_OK, 8'h81, -1, -1, -1, -1, -1, -1));
      send_item(REQ_SAMPLE, sample_fields(100000, BUS_OK, 8'h01,
                                          100, -200, 300, -400, 500, -600));
      send_item(REQ_FETCH, random_noise());

      wait_quiet();
      write_settings(16'd0, 16'd0, 1'b1);
      send_item(REQ_SAMPLE, sample_fields(0, BUS_OK, 8'h01, 100, -200, 300, -400, 500, -600));
      send_item(REQ_SAMPLE, sample_fields(0, BUS_OK, 8'h01,
                                          -32768, 32767, -1, 32767, -32768, 1));
      send_item(REQ_FETCH, random_noise());
      send_item(REQ_FETCH, random_noise());

      wait_quiet();
      write_settings(16'hffff, 16'hffff, 1'b0);
      send_item(REQ_SAMPLE, sample_fields(32'hffff_fff0, BUS_OK, 8'h01, 1, 2, 3, 4, 5, 6));
      send_item(REQ_SAMPLE, sample_fields(32'h0000_ffef, BUS_OK, 8'h01,
                                          -7, -8, -9, -10, -11, -12));
      send_item(REQ_SAMPLE, sample_fields(32'h0001_ffed, BUS_OK, 8'h01, 3, 3, 3, 3, 3, 3));
      send_item(REQ_FETCH, random_noise());

      tb_now = 32'h0001_0000;
      for (int phase = 0; phase < 4; phase++) begin
         wait_quiet();
         case (phase)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
               write_settings(16'($urandom_range(3000)), 16'd1, 1'b0);
            end
            1: begin
               idle_pct = 63;
               stall_pct = 0;
               write_settings(16'hffff, 16'hffff, 1'b1);
            end
            2: begin
               idle_pct = 0;
               stall_pct = 63;
               tb_now = 32'hffff_0000;
               write_settings(16'($urandom_range(20000)), 16'($urandom), 1'b1);
            end
            default: begin
               idle_pct = 18;
               stall_pct = 18;
               write_settings(16'($urandom_range(20000)), 16'($urandom), 1'b0);
            end
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (phase == 0 && k == 40) begin
               hold_cycles = 400;
            end
            if (k == PHASE_ITEMS / 2) begin
               wait_quiet();
            end
            random_item();
         end
      end

      wait_quiet();
      repeat (50) @(posedge clock);
      $display("Covered %0d items, %0d of them fetches, under %0d register settings,",
               items_sent, fetches_sent, settings_used);
      $display("with idle senders, stalled receivers and a long hold; %0d results checked.",
               results_checked);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
